// ===== rtl/rrfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rrfp_pkg
// Types, codes and the fixed-field width table of the row record parser.
// ----------------------------------------------------------------------------
package rrfp_pkg;

  localparam logic [7:0] CHAR_D = 8'h44;
  localparam logic [7:0] CHAR_Z = 8'h5A;

  localparam int unsigned KindW = 4;
  localparam int unsigned ValueW = 64;

  localparam logic [KindW-1:0] KIND_STR = 4'd0;
  localparam logic [KindW-1:0] KIND_QTY = 4'd9;
  localparam logic [KindW-1:0] KIND_END = 4'd10;
  localparam logic [KindW-1:0] KIND_BAD = 4'd11;

  localparam logic [3:0] LAST_FIELD = 4'd8;

  typedef enum logic [2:0] {
    PH_TYPE   = 3'd0,
    PH_SIZE   = 3'd1,
    PH_LEN    = 3'd2,
    PH_STR    = 3'd3,
    PH_PREFIX = 3'd4,
    PH_VALUE  = 3'd5
  } phase_e;

  typedef struct packed {
    phase_e              phase;
    logic [2:0]          byte_idx;
    logic [31:0]         str_rem;
    logic [ValueW-1:0]   acc;
    logic [3:0]          field_num;
  } rrfp_state_t;

  typedef struct packed {
    logic                valid;
    logic [KindW-1:0]    kind;
    logic [ValueW-1:0]   value;
    logic                last;
  } rrfp_result_t;

  // value width in bytes of each fixed field
  function automatic logic [3:0] field_width(input logic [3:0] fnum);
    logic [3:0] w;
    case (fnum)
      4'd0, 4'd1: w = 4'd8;
      4'd2, 4'd3: w = 4'd4;
      default:    w = 4'd1;
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/row_record_field_parser.sv =====
// ----------------------------------------------------------------------------
// row_record_field_parser
// Decodes a byte stream of row records into typed field items.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one record byte per item on s_axis_tdata. Master side
//   gives one decoded field per item: field_value on m_axis_tdata, field_kind
//   on m_axis_tuser, row_last on m_axis_tlast (high on the quantity field).
//   A 'D' type byte, size, length and prefix words and every value byte but
//   the last of a field give no output item.
// Path: an accepted byte goes through an input register and a result
//   register; its result is shown once the result register can advance.
// Throughput: one byte per cycle while the sink takes each item; the parse
//   step is a single pass of logic between the two registers.
// Stall: while the result register holds an untaken item the pipeline
//   holds; one more byte can enter the empty input register, after which
//   s_axis_tready stays low until the sink takes the waiting item.
// Reset: clears both registers and the parse state; the block then waits
//   for a type byte.
// ----------------------------------------------------------------------------
module row_record_field_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] field_value
  output logic [3:0]  m_axis_tuser,   // [3:0] field_kind
  output logic        m_axis_tlast    // row_last
);
  import rrfp_pkg::*;

  logic         in_vld_q;
  logic [7:0]   in_byte_q;
  rrfp_state_t  st_q, st_d;
  rrfp_result_t step_res;
  logic         out_vld_q;
  logic [63:0]  out_val_q;
  logic [3:0]   out_kind_q;
  logic         out_last_q;
  logic         advance;
  logic         fire;

  assign advance       = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;

  rrfp_step u_step (
    .state_i  (st_q),
    .byte_i   (in_byte_q),
    .state_o  (st_d),
    .result_o (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      in_byte_q  <= '0;
      st_q       <= '0;
      out_vld_q  <= 1'b0;
      out_val_q  <= '0;
      out_kind_q <= '0;
      out_last_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q  <= s_axis_tvalid;
        in_byte_q <= s_axis_tdata;
      end
      if (fire) begin
        st_q <= st_d;
      end
      if (advance) begin
        // bytes that give no result leave the output slot empty
        out_vld_q  <= fire && step_res.valid;
        out_val_q  <= step_res.value;
        out_kind_q <= step_res.kind;
        out_last_q <= step_res.last;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_val_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/rrfp_step.sv =====
// ----------------------------------------------------------------------------
// rrfp_step
// Next-state and result logic for one byte of the record stream.
// ----------------------------------------------------------------------------
module rrfp_step (
  input  rrfp_pkg::rrfp_state_t  state_i,
  input  logic [7:0]             byte_i,
  output rrfp_pkg::rrfp_state_t  state_o,
  output rrfp_pkg::rrfp_result_t result_o
);
  import rrfp_pkg::*;

  logic [31:0]       rem_new;
  logic [31:0]       rem_dec;
  logic [ValueW-1:0] acc_new;
  logic [3:0]        fnum;
  logic [3:0]        idx_inc;

  assign rem_new = state_i.str_rem | (32'(byte_i) << {state_i.byte_idx[1:0], 3'b000});
  assign rem_dec = state_i.str_rem - 32'd1;
  assign acc_new = state_i.acc | (64'(byte_i) << {state_i.byte_idx, 3'b000});
  assign fnum    = (state_i.field_num > LAST_FIELD) ? LAST_FIELD : state_i.field_num;
  assign idx_inc = {1'b0, state_i.byte_idx} + 4'd1;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    case (state_i.phase)
      PH_TYPE: begin
        if (byte_i == CHAR_Z) begin
          result_o.valid = 1'b1;
          result_o.kind  = KIND_END;
        end else if (byte_i == CHAR_D) begin
          state_o.phase    = PH_SIZE;
          state_o.byte_idx = '0;
        end else begin
          result_o.valid = 1'b1;
          result_o.kind  = KIND_BAD;
        end
      end
      PH_SIZE: begin
        if (state_i.byte_idx == 3'd3) begin
          state_o.phase    = PH_LEN;
          state_o.byte_idx = '0;
          state_o.str_rem  = '0;
        end else begin
          state_o.byte_idx = idx_inc[2:0];
        end
      end
      PH_LEN: begin
        state_o.str_rem = rem_new;
        if (state_i.byte_idx == 3'd3) begin
          state_o.byte_idx  = '0;
          state_o.field_num = '0;
          state_o.phase     = (rem_new != 32'd0) ? PH_STR : PH_PREFIX;
        end else begin
          state_o.byte_idx = idx_inc[2:0];
        end
      end
      PH_STR: begin
        result_o.valid  = 1'b1;
        result_o.kind   = KIND_STR;
        result_o.value  = 64'(byte_i);
        state_o.str_rem = rem_dec;
        if (rem_dec == 32'd0) begin
          state_o.phase    = PH_PREFIX;
          state_o.byte_idx = '0;
        end
      end
      PH_PREFIX: begin
        if (state_i.byte_idx == 3'd3) begin
          state_o.byte_idx = '0;
          state_o.acc      = '0;
          state_o.phase    = PH_VALUE;
        end else begin
          state_o.byte_idx = idx_inc[2:0];
        end
      end
      PH_VALUE: begin
        state_o.field_num = fnum;
        if (idx_inc >= field_width(fnum)) begin
          result_o.valid   = 1'b1;
          result_o.kind    = fnum + 4'd1;
          result_o.value   = acc_new;
          result_o.last    = (fnum == LAST_FIELD);
          state_o.byte_idx = '0;
          state_o.acc      = '0;
          if (fnum == LAST_FIELD) begin
            state_o.field_num = '0;
            state_o.phase     = PH_TYPE;
          end else begin
            state_o.field_num = fnum + 4'd1;
            state_o.phase     = PH_PREFIX;
          end
        end else begin
          state_o.byte_idx = idx_inc[2:0];
          state_o.acc      = acc_new;
        end
      end
      default: begin
        // unused phase code: back to a clean start
        state_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/rrfp_checker.sv =====
// ----------------------------------------------------------------------------
// rrfp_port_checks
// Port-level checks on the output items of the row record parser.
// ----------------------------------------------------------------------------
module rrfp_port_checks (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import rrfp_pkg::*;

  // stalled item holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  a_last_qty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_QTY)))
    else $error("row end flag not on quantity field");

  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_END || m_axis_tuser == KIND_BAD)
      |-> m_axis_tdata == 64'd0)
    else $error("marker item carries a value");

  a_str_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_STR |-> m_axis_tdata[63:8] == 56'd0)
    else $error("string item wider than a byte");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= KIND_BAD)
    else $error("field kind out of range");

endmodule

bind row_record_field_parser rrfp_port_checks u_rrfp_port_checks (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/rrfp_checker.sv =====
// ----------------------------------------------------------------------------
// rrfp_checker
// Watches both streams of the row record parser. It decodes every accepted
// byte with its own parse state and queues the field item it implies. Each
// accepted output item is compared field by field against the oldest queued
// field.
// ----------------------------------------------------------------------------
module rrfp_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_valid_i,
  input  logic              byte_ready_i,
  input  logic [7:0]        byte_data_i,
  input  logic              field_valid_i,
  input  logic              field_ready_i,
  input  logic [63:0]       field_value_i,
  input  logic [3:0]        field_kind_i,
  input  logic              field_last_i,
  output int                fail_cnt_o,
  output int                pending_o,
  output rrfp_pkg::phase_e  phase_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rrfp_pkg::*;

  typedef struct packed {
    logic [3:0]  kind;
    logic [63:0] value;
    logic        last;
  } field_rec_t;

  // value bytes per fixed field, field 0 in the lowest nibble
  localparam logic [35:0] FIELD_BYTES = {4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
                                         4'd4, 4'd4, 4'd8, 4'd8};

  field_rec_t  expected_fields[$];
  phase_e      phase;
  logic [3:0]  byte_idx;
  logic [31:0] str_left;
  logic [63:0] acc;
  logic [3:0]  field_num;

  assign phase_o = phase;

  task automatic clear_parse();
    phase     = PH_TYPE;
    byte_idx  = '0;
    str_left  = '0;
    acc       = '0;
    field_num = '0;
  endtask

  task automatic expect_field(input logic [3:0] kind, input logic [63:0] value,
                              input logic last);
    field_rec_t rec;
    rec.kind  = kind;
    rec.value = value;
    rec.last  = last;
    expected_fields.push_back(rec);
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [3:0] need;
    logic       is_last;
    case (phase)
      PH_TYPE: begin
        if (b == CHAR_Z) begin
          expect_field(KIND_END, '0, 1'b0);
        end else if (b == CHAR_D) begin
          phase    = PH_SIZE;
          byte_idx = '0;
        end else begin
          expect_field(KIND_BAD, '0, 1'b0);
        end
      end
      PH_SIZE: begin
        byte_idx = byte_idx + 4'd1;
        if (byte_idx >= 4'd4) begin
          phase    = PH_LEN;
          byte_idx = '0;
          str_left = '0;
        end
      end
      PH_LEN: begin
        str_left = str_left | (32'(b) << (8 * byte_idx[1:0]));
        byte_idx = byte_idx + 4'd1;
        if (byte_idx >= 4'd4) begin
          byte_idx  = '0;
          field_num = '0;
          phase     = (str_left != '0) ? PH_STR : PH_PREFIX;
        end
      end
      PH_STR: begin
        expect_field(KIND_STR, 64'(b), 1'b0);
        str_left = str_left - 32'd1;
        if (str_left == '0) begin
          phase    = PH_PREFIX;
          byte_idx = '0;
        end
      end
      PH_PREFIX: begin
        byte_idx = byte_idx + 4'd1;
        if (byte_idx >= 4'd4) begin
          byte_idx = '0;
          acc      = '0;
          phase    = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (field_num > LAST_FIELD) field_num = LAST_FIELD;
        acc      = acc | (64'(b) << (8 * byte_idx[2:0]));
        byte_idx = byte_idx + 4'd1;
        need     = FIELD_BYTES[field_num * 4 +: 4];
        if (byte_idx >= need) begin
          is_last = (field_num == LAST_FIELD);
          expect_field(field_num + 4'd1, acc, is_last);
          byte_idx = '0;
          acc      = '0;
          if (is_last) begin
            field_num = '0;
            phase     = PH_TYPE;
          end else begin
            field_num = field_num + 4'd1;
            phase     = PH_PREFIX;
          end
        end
      end
      default: clear_parse();
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    field_rec_t want;
    if (!rst_ni) begin
      clear_parse();
      expected_fields.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      // outputs first: a byte taken at this edge cannot show up yet
      if (field_valid_i && field_ready_i) begin
        if (expected_fields.size() == 0) begin
          $display("%0t: unexpected item kind %0d value %h last %b", $time,
                   field_kind_i, field_value_i, field_last_i);
          fail_cnt_o = fail_cnt_o + 1;
        end else begin
          want = expected_fields.pop_front();
          if (field_kind_i !== want.kind) begin
            $display("%0t: field_kind expected %0d got %0d", $time, want.kind,
                     field_kind_i);
            fail_cnt_o = fail_cnt_o + 1;
          end
          if (field_value_i !== want.value) begin
            $display("%0t: field_value expected %h got %h", $time, want.value,
                     field_value_i);
            fail_cnt_o = fail_cnt_o + 1;
          end
          if (field_last_i !== want.last) begin
            $display("%0t: row_last expected %b got %b", $time, want.last,
                     field_last_i);
            fail_cnt_o = fail_cnt_o + 1;
          end
        end
      end
      if (byte_valid_i && byte_ready_i) decode_byte(byte_data_i);
      pending_o = expected_fields.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the row record parser.
// Sends end and malformed type bytes and well-formed rows with random,
// all-ones or all-zeros content. It also sends cut rows and stray bytes. Both
// sides idle at changing rates, and the sink holds off once for a long
// stretch. Checking is done by rrfp_checker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rrfp_pkg::*;

  localparam int NumBytes   = 1050;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 400;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int          fail_cnt;
  int          pending;
  phase_e      parse_phase;
  int          sent_cnt;
  int          cycle_cnt;
  int          src_idle_pct;
  int          sink_idle_pct;
  bit          hold_req;
  logic [7:0]  row_bytes[$];

  row_record_field_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  rrfp_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (s_axis_tvalid),
    .byte_ready_i  (s_axis_tready),
    .byte_data_i   (s_axis_tdata),
    .field_valid_i (m_axis_tvalid),
    .field_ready_i (m_axis_tready),
    .field_value_i (m_axis_tdata),
    .field_kind_i  (m_axis_tuser),
    .field_last_i  (m_axis_tlast),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending),
    .phase_o       (parse_phase)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // sink: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic logic [7:0] pick_byte(input fill_e mode);
    logic [7:0] b;
    case (mode)
      FILL_ONES:  b = 8'hFF;
      FILL_ZEROS: b = 8'h00;
      default: begin
        case ($urandom_range(7))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom());
        endcase
      end
    endcase
    return b;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_cnt = sent_cnt + 1;
    @(negedge clk_i);
  endtask

  task automatic build_row(input logic [31:0] len, input fill_e mode);
    row_bytes.delete();
    row_bytes.push_back(CHAR_D);
    for (int k = 0; k < 4; k++) row_bytes.push_back(pick_byte(mode));
    for (int k = 0; k < 4; k++) row_bytes.push_back(len[8*k +: 8]);
    for (int i = 0; i < int'(len); i++) row_bytes.push_back(pick_byte(mode));
    for (int f = 0; f <= int'(LAST_FIELD); f++) begin
      for (int k = 0; k < 4; k++) row_bytes.push_back(pick_byte(mode));
      for (int k = 0; k < int'(field_width(4'(f))); k++)
        row_bytes.push_back(pick_byte(mode));
    end
  endtask

  task automatic send_row_bytes(input int count);
    for (int i = 0; i < count; i++) send_byte(row_bytes[i]);
  endtask

  // walk the parser back to a type byte; the length bytes it sends are zero
  task automatic fill_to_type();
    while (parse_phase != PH_TYPE)
      send_byte((parse_phase == PH_LEN) ? 8'h00 : pick_byte(FILL_RANDOM));
  endtask

  initial begin
    int    pick;
    int    len;
    bit    held;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    hold_req      = 1'b0;
    held          = 1'b0;
    sent_cnt      = 0;
    cycle_cnt     = 0;
    src_idle_pct  = 36;
    sink_idle_pct = 62;
    @(posedge rst_ni);
    @(negedge clk_i);

    // directed: markers, extreme bytes, empty and short strings, a cut row
    send_byte(CHAR_Z);
    send_byte(8'h00);
    send_byte(8'hFF);
    build_row(32'd0, FILL_ONES);
    send_row_bytes(row_bytes.size());
    build_row(32'd1, FILL_ZEROS);
    send_row_bytes(row_bytes.size());
    send_byte(CHAR_Z);
    build_row(32'd3, FILL_RANDOM);
    send_row_bytes(3);
    fill_to_type();

    while (sent_cnt < NumBytes) begin
      if (sent_cnt < NumBytes / 3) begin
        src_idle_pct  = 36;
        sink_idle_pct = 62;
      end else if (sent_cnt < 2 * NumBytes / 3) begin
        src_idle_pct  = 62;
        sink_idle_pct = 36;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        if (!held) begin
          held = 1'b1;
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
          hold_req = 1'b1;
          @(negedge clk_i);
        end
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
        build_row(32'(len), FILL_RANDOM);
        send_row_bytes(row_bytes.size());
      end else if (pick < 78) begin
        send_byte(CHAR_Z);
      end else if (pick < 86) begin
        send_byte(8'($urandom()));
        fill_to_type();
      end else begin
        build_row(32'($urandom_range(6)), FILL_RANDOM);
        send_row_bytes($urandom_range(1, row_bytes.size() - 1));
        fill_to_type();
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rrfp_pkg.sv
rtl/rrfp_step.sv
rtl/row_record_field_parser.sv
rtl/rrfp_checker.sv
tb/rrfp_checker.sv
tb/tb.sv
